// File: hdl/fbc_pkg.sv
package fbc_pkg;

    localparam int HALF_W  = 16;
    localparam int BLOCK_W = 2 * HALF_W;
    localparam int KEY_W   = 4 * HALF_W;
    localparam int RCNT_W  = 6;
    localparam int CIDX_W  = 8;

    // The key window holds the last eight round keys.
    localparam int WIN_DEPTH = 8;

    localparam int ROT_A = 3;
    localparam int ROT_B = 9;
    localparam int ROT_C = 14;

    localparam logic [CIDX_W-1:0] CFG_CIPHER_KEY  = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_ROUND_COUNT = CIDX_W'(1);

    localparam logic [RCNT_W-1:0] ROUND_COUNT_RESET = RCNT_W'(16);

    typedef logic [HALF_W-1:0] half_t;

    function automatic half_t rotl(input half_t v, input int s);
        half_t res;
        res = (v << s) | (v >> (HALF_W - s));
        return res;
    endfunction

endpackage

// File: hdl/fbc_round.sv
// One cipher round: nonlinear mix of the left half under the round key and
// round index, followed by the half swap.
module fbc_round
(
    input  fbc_pkg::half_t round_key,
    input  fbc_pkg::half_t round_num,
    input  fbc_pkg::half_t left_in,
    input  fbc_pkg::half_t right_in,
    output fbc_pkg::half_t left_out,
    output fbc_pkg::half_t right_out
);

    fbc_pkg::half_t t1;
    fbc_pkg::half_t t2;
    fbc_pkg::half_t t3;

    always_comb
    begin
        t1 = (round_key & left_in) ^ right_in ^ round_num;
        t2 = ((t1 << 2) & (t1 << 1)) ^ t1;
        t3 = fbc_pkg::rotl(t2, fbc_pkg::ROT_A)
           ^ fbc_pkg::rotl(t2, fbc_pkg::ROT_B)
           ^ fbc_pkg::rotl(t2, fbc_pkg::ROT_C);
    end

    assign left_out  = right_in ^ (round_key & t3);
    assign right_out = left_in ^ t3;

endmodule

// File: hdl/feistel_block_cipher_32_core.sv
// 32-bit Feistel block cipher core. Each beat on the input channel carries one
// plaintext block (low half is the left half, high half the right half) and
// produces one ciphertext beat. The block runs one round per clock through a
// single shared round unit, generating each round key on the fly from the
// 64-bit key and an eight-entry window of earlier round keys. With
// n = min(round_count, MAX_ROUNDS), an accepted block runs n rounds in
// ST_RUN, and ST_FINISH then hands the result to the output register once
// it is free; the input is stalled while a block is in flight, and a
// finished result waits in the output register while the output side
// stalls. A round count of zero returns the plaintext unchanged. Registers
// are written through the configuration channel: index 0 is the key, index
// 1 the round count (reset 16); other indexes are ignored. Configuration is
// expected only while idle.
module feistel_block_cipher_32_core
#(
    parameter int MAX_ROUNDS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [fbc_pkg::BLOCK_W-1:0]  plaintext,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fbc_pkg::BLOCK_W-1:0]  ciphertext,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fbc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [fbc_pkg::KEY_W-1:0]    cfg_data
);

    // Wide enough to hold both MAX_ROUNDS and any round_count value.
    localparam int CNT_W = ($clog2(MAX_ROUNDS + 1) > fbc_pkg::RCNT_W) ?
                           $clog2(MAX_ROUNDS + 1) : fbc_pkg::RCNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t                         state_reg;
    logic [fbc_pkg::KEY_W-1:0]      cipher_key_reg;
    logic [fbc_pkg::RCNT_W-1:0]     round_count_reg;
    logic [CNT_W-1:0]               rounds_reg;
    logic [CNT_W-1:0]               round_reg;
    fbc_pkg::half_t                 left_reg;
    fbc_pkg::half_t                 right_reg;
    fbc_pkg::half_t                 window_reg [fbc_pkg::WIN_DEPTH];
    logic                           out_valid_reg;
    logic [fbc_pkg::BLOCK_W-1:0]    ciphertext_reg;

    logic [CNT_W-1:0]               rounds_next;
    fbc_pkg::half_t                 round_key;
    fbc_pkg::half_t                 round_num;
    fbc_pkg::half_t                 left_next;
    fbc_pkg::half_t                 right_next;
    logic                           in_take;
    logic                           out_free;

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign ciphertext = ciphertext_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // Saturate the configured count at MAX_ROUNDS.
    always_comb
    begin
        if (CNT_W'(round_count_reg) > CNT_W'(MAX_ROUNDS))
        begin
            rounds_next = CNT_W'(MAX_ROUNDS);
        end
        else
        begin
            rounds_next = CNT_W'(round_count_reg);
        end
    end

    assign round_num = fbc_pkg::HALF_W'(round_reg);

    // Round key generation. window_reg[0] holds the key of the previous round
    // and window_reg[WIN_DEPTH-1] the key from eight rounds back. Both are
    // always written earlier within the same block before they are read.
    always_comb
    begin
        if (round_reg[0])
        begin
            round_key = ~window_reg[0];
        end
        else if ((round_reg >> 3) == '0)
        begin
            round_key = cipher_key_reg[round_reg[2:1] * fbc_pkg::HALF_W +: fbc_pkg::HALF_W];
        end
        else
        begin
            round_key = ~window_reg[fbc_pkg::WIN_DEPTH-1]
                      ^ (fbc_pkg::HALF_W'(round_reg >> 1) - fbc_pkg::HALF_W'(4));
        end
    end

    fbc_round u_round
    (
        .round_key (round_key),
        .round_num (round_num),
        .left_in   (left_reg),
        .right_in  (right_reg),
        .left_out  (left_next),
        .right_out (right_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cipher_key_reg  <= '0;
            round_count_reg <= fbc_pkg::ROUND_COUNT_RESET;
            rounds_reg      <= '0;
            round_reg       <= '0;
            left_reg        <= '0;
            right_reg       <= '0;
            out_valid_reg   <= 1'b0;
            ciphertext_reg  <= '0;
            for (int i = 0; i < fbc_pkg::WIN_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fbc_pkg::CFG_CIPHER_KEY:  cipher_key_reg  <= cfg_data;
                    fbc_pkg::CFG_ROUND_COUNT: round_count_reg <= cfg_data[fbc_pkg::RCNT_W-1:0];
                    default: ;
                endcase
            end

            // A finished block loads the output register once it is free;
            // otherwise an accepted beat empties it.
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        left_reg   <= plaintext[fbc_pkg::HALF_W-1:0];
                        right_reg  <= plaintext[fbc_pkg::BLOCK_W-1:fbc_pkg::HALF_W];
                        rounds_reg <= rounds_next;
                        round_reg  <= '0;
                        state_reg  <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (round_reg == rounds_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        left_reg      <= left_next;
                        right_reg     <= right_next;
                        round_reg     <= round_reg + CNT_W'(1);
                        window_reg[0] <= round_key;
                        for (int i = 1; i < fbc_pkg::WIN_DEPTH; i++)
                        begin
                            window_reg[i] <= window_reg[i-1];
                        end
                        if (round_reg + CNT_W'(1) == rounds_reg)
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    // Hand the block to the output register once it is free.
                    if (out_free)
                    begin
                        ciphertext_reg <= {right_reg, left_reg};
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
